// ----- sv/triangle_plane_clipper_assert.svh -----
// Assertion macros shared by the triangle plane clipper RTL.
// Plain concurrent properties on a rising clock with an active-low reset.
`ifndef TRIANGLE_PLANE_CLIPPER_ASSERT_SVH
`define TRIANGLE_PLANE_CLIPPER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPC_ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("triangle plane clipper: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define TPC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("triangle plane clipper: next-cycle property failed");

`endif

// ----- sv/tpc_pkg.sv -----
// Shared types and constants of the triangle plane clipper.
// No dependencies; the files that use it refer to it by scoped names.
package tpc_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int SIDE_DEPTH  = 24;
    localparam int DIV_STAGES  = 16;

    localparam logic [1:0] REG_NORMAL_X     = 2'd0;
    localparam logic [1:0] REG_NORMAL_Y     = 2'd1;
    localparam logic [1:0] REG_NORMAL_Z     = 2'd2;
    localparam logic [1:0] REG_PLANE_OFFSET = 2'd3;

    // Plane value n.p + d as an exact Q35.32 number.
    typedef logic signed [66:0] sval_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vert_t;

    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_ONE  = 2'd1,
        MODE_TWO  = 2'd2
    } mode_t;

    // Classified triangle, vertices already reordered so kept ones lead.
    typedef struct packed {
        vert_t a;
        vert_t b;
        vert_t c;
        sval_t sa;
        sval_t sb;
        sval_t sc;
        mode_t mode;
    } qitem_t;

    typedef struct packed {
        vert_t a;
        vert_t b;
        vert_t c;
        mode_t mode;
    } side_t;

    // One edge to cut: from kept vertex p to dropped vertex q.
    typedef struct packed {
        logic  slot;
        vert_t p;
        vert_t q;
        sval_t sp;
        sval_t sq;
    } edge_t;

    typedef struct packed {
        logic  slot;
        vert_t v;
    } cut_res_t;

    typedef struct packed {
        vert_t a;
        vert_t b;
        vert_t c;
        logic  last;
    } tri_t;

endpackage

// ----- sv/tpc_fifo.sv -----
// Small register FIFO used for the classified-triangle queue and the item store.
// Depends on nothing; width and depth come from the instantiating module.
module tpc_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- sv/tpc_front.sv -----
// Front end: plane registers, plane values of the three vertices and classification.
// Depends on tpc_pkg; feeds the classified-triangle queue.
module tpc_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  tpc_pkg::vert_t [2:0]    vin,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [31:0]             cfg_data,
    input  logic                    q_full,
    output logic                    q_push,
    output tpc_pkg::qitem_t         q_item
);

    logic signed [31:0] nx_reg, ny_reg, nz_reg, d_reg;

    logic                 f_adv;
    logic                 s1_v_reg;
    tpc_pkg::vert_t [2:0] s1_vert_reg;
    logic signed [63:0]   s1_prod_reg [3][3];
    logic signed [63:0]   prod_next [3][3];

    logic                 s2_v_reg;
    tpc_pkg::vert_t [2:0] s2_vert_reg;
    tpc_pkg::sval_t       s2_s_reg [3];
    tpc_pkg::sval_t       s_next [3];

    logic [2:0]           keep;
    logic                 need;
    logic [1:0]           o0, o1, o2;
    tpc_pkg::mode_t       mode;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg <= '0;
            ny_reg <= '0;
            nz_reg <= '0;
            d_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tpc_pkg::REG_NORMAL_X:     nx_reg <= cfg_data;
                tpc_pkg::REG_NORMAL_Y:     ny_reg <= cfg_data;
                tpc_pkg::REG_NORMAL_Z:     nz_reg <= cfg_data;
                tpc_pkg::REG_PLANE_OFFSET: d_reg  <= cfg_data;
                default:                   d_reg  <= d_reg;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            prod_next[i][0] = vin[i].x * nx_reg;
            prod_next[i][1] = vin[i].y * ny_reg;
            prod_next[i][2] = vin[i].z * nz_reg;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s_next[i] = {{3{s1_prod_reg[i][0][63]}}, s1_prod_reg[i][0]}
                      + {{3{s1_prod_reg[i][1][63]}}, s1_prod_reg[i][1]}
                      + {{3{s1_prod_reg[i][2][63]}}, s1_prod_reg[i][2]}
                      + {{19{d_reg[31]}}, d_reg, 16'h0000};
        end
    end

    // A stage moves only when the queue can take what the last stage holds.
    assign need     = s2_v_reg && (keep != 3'b000);
    assign f_adv    = !(need && q_full);
    assign in_stall = !f_adv;
    assign q_push   = need && !q_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else if (f_adv)
        begin
            s1_v_reg <= in_valid;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_adv)
        begin
            s1_vert_reg <= vin;
            s1_prod_reg <= prod_next;
            s2_vert_reg <= s1_vert_reg;
            s2_s_reg    <= s_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            keep[2 - i] = !s2_s_reg[i][66];
        end
    end

    // keep[2] is the first vertex; kept vertices are moved to the front.
    always_comb
    begin
        o0   = 2'd0;
        o1   = 2'd1;
        o2   = 2'd2;
        mode = tpc_pkg::MODE_ONE;
        case (keep)
            3'b111: mode = tpc_pkg::MODE_PASS;
            3'b011:
            begin
                o0   = 2'd2;
                o2   = 2'd0;
                mode = tpc_pkg::MODE_TWO;
            end
            3'b010:
            begin
                o0 = 2'd1;
                o1 = 2'd0;
            end
            3'b001:
            begin
                o0 = 2'd2;
                o2 = 2'd0;
            end
            3'b101:
            begin
                o1   = 2'd2;
                o2   = 2'd1;
                mode = tpc_pkg::MODE_TWO;
            end
            3'b110: mode = tpc_pkg::MODE_TWO;
            default: mode = tpc_pkg::MODE_ONE;
        endcase
    end

    always_comb
    begin
        q_item.a    = s2_vert_reg[o0];
        q_item.b    = s2_vert_reg[o1];
        q_item.c    = s2_vert_reg[o2];
        q_item.sa   = s2_s_reg[o0];
        q_item.sb   = s2_s_reg[o1];
        q_item.sc   = s2_s_reg[o2];
        q_item.mode = mode;
    end

endmodule

// ----- sv/tpc_cut.sv -----
// Edge cutter: normalizes the plane values, divides for t in a pipelined
// restoring divider, scales the edge and rounds. Depends on tpc_pkg.
module tpc_cut (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              edge_v,
    input  tpc_pkg::edge_t    edge_in,
    output logic              res_v,
    output tpc_pkg::cut_res_t res
);

    localparam int NDIV     = tpc_pkg::DIV_STAGES;
    localparam int BITS_PER = 32 / NDIV;

    typedef struct packed {
        logic               slot;
        tpc_pkg::vert_t     p;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic signed [32:0] dz;
    } carry_t;

    typedef struct packed {
        carry_t      c;
        logic [30:0] d;
        logic [30:0] r;
        logic [31:0] q;
    } dst_t;

    function automatic logic [31:0] div_step(logic [30:0] r, logic [30:0] d, logic first);
        logic [31:0] rs;
        logic [31:0] diff;
        rs   = first ? {1'b0, r} : {r, 1'b0};
        diff = rs - {1'b0, d};
        if (rs >= {1'b0, d})
        begin
            return {1'b1, diff[30:0]};
        end
        return {1'b0, rs[30:0]};
    endfunction

    // Rounds t*(q-p)/2^31 half away from zero and adds it to p.
    function automatic logic signed [31:0] apply_cut(logic signed [31:0] p,
                                                     logic signed [65:0] d);
        logic [65:0] mag;
        logic [65:0] sum;
        logic [31:0] r;
        mag = d[65] ? 66'(-d) : 66'(d);
        sum = mag + 66'h0_4000_0000;
        r   = sum[62:31];
        return d[65] ? $signed(p - r) : $signed(p + r);
    endfunction

    logic        e_v_reg;
    carry_t      e_c_reg;
    logic [66:0] e_num_reg;
    logic [67:0] e_den_reg;
    carry_t      e_c_next;
    logic [67:0] den_next;

    logic        n1_v_reg;
    carry_t      n1_c_reg;
    logic [66:0] n1_num_reg;
    logic [67:0] n1_den_reg;
    logic [6:0]  n1_sh_reg;
    logic [6:0]  msb;
    logic [6:0]  sh_next;

    logic        n2_v_reg;
    dst_t        n2_reg;
    logic [66:0] num_sh;
    logic [67:0] den_sh;

    logic        dv_v_reg [NDIV];
    dst_t        dv_reg [NDIV];
    dst_t        dv_next [NDIV];
    dst_t        src;
    logic [31:0] st;

    logic               m_v_reg;
    logic               m_slot_reg;
    tpc_pkg::vert_t     m_p_reg;
    logic signed [65:0] m_dx_reg, m_dy_reg, m_dz_reg;
    logic signed [32:0] t_s;

    logic              r_v_reg;
    tpc_pkg::cut_res_t r_reg;

    always_comb
    begin
        e_c_next.slot = edge_in.slot;
        e_c_next.p    = edge_in.p;
        e_c_next.dx   = {edge_in.q.x[31], edge_in.q.x} - {edge_in.p.x[31], edge_in.p.x};
        e_c_next.dy   = {edge_in.q.y[31], edge_in.q.y} - {edge_in.p.y[31], edge_in.p.y};
        e_c_next.dz   = {edge_in.q.z[31], edge_in.q.z} - {edge_in.p.z[31], edge_in.p.z};
        den_next      = {edge_in.sp[66], edge_in.sp} - {edge_in.sq[66], edge_in.sq};
    end

    // Shift that brings the denominator just below 2^31.
    always_comb
    begin
        msb = '0;
        for (int i = 0; i < 68; i++)
        begin
            if (e_den_reg[i])
            begin
                msb = 7'(i);
            end
        end
        sh_next = (msb > 7'd30) ? msb - 7'd30 : 7'd0;
    end

    assign num_sh = n1_num_reg >> n1_sh_reg;
    assign den_sh = n1_den_reg >> n1_sh_reg;

    always_comb
    begin
        for (int i = 0; i < NDIV; i++)
        begin
            if (i == 0)
            begin
                src = n2_reg;
            end
            else
            begin
                src = dv_reg[i - 1];
            end
            for (int b = 0; b < BITS_PER; b++)
            begin
                st    = div_step(src.r, src.d, (i == 0) && (b == 0));
                src.r = st[30:0];
                src.q = {src.q[30:0], st[31]};
            end
            dv_next[i] = src;
        end
    end

    assign t_s = $signed({1'b0, dv_reg[NDIV - 1].q});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_v_reg  <= 1'b0;
            n1_v_reg <= 1'b0;
            n2_v_reg <= 1'b0;
            m_v_reg  <= 1'b0;
            r_v_reg  <= 1'b0;
            for (int i = 0; i < NDIV; i++)
            begin
                dv_v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            e_v_reg  <= edge_v;
            n1_v_reg <= e_v_reg;
            n2_v_reg <= n1_v_reg;
            dv_v_reg[0] <= n2_v_reg;
            for (int i = 1; i < NDIV; i++)
            begin
                dv_v_reg[i] <= dv_v_reg[i - 1];
            end
            m_v_reg <= dv_v_reg[NDIV - 1];
            r_v_reg <= m_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_c_reg    <= e_c_next;
            e_num_reg  <= edge_in.sp;
            e_den_reg  <= den_next;
            n1_c_reg   <= e_c_reg;
            n1_num_reg <= e_num_reg;
            n1_den_reg <= e_den_reg;
            n1_sh_reg  <= sh_next;
            n2_reg.c   <= n1_c_reg;
            n2_reg.d   <= den_sh[30:0];
            n2_reg.r   <= num_sh[30:0];
            n2_reg.q   <= '0;
            dv_reg     <= dv_next;
            m_slot_reg <= dv_reg[NDIV - 1].c.slot;
            m_p_reg    <= dv_reg[NDIV - 1].c.p;
            m_dx_reg   <= t_s * dv_reg[NDIV - 1].c.dx;
            m_dy_reg   <= t_s * dv_reg[NDIV - 1].c.dy;
            m_dz_reg   <= t_s * dv_reg[NDIV - 1].c.dz;
            r_reg.slot <= m_slot_reg;
            r_reg.v.x  <= apply_cut(m_p_reg.x, m_dx_reg);
            r_reg.v.y  <= apply_cut(m_p_reg.y, m_dy_reg);
            r_reg.v.z  <= apply_cut(m_p_reg.z, m_dz_reg);
        end
    end

    assign res_v = r_v_reg;
    assign res   = r_reg;

endmodule

// ----- sv/tpc_back.sv -----
// Back end: issues the cut edges of each queued triangle, keeps the triangle
// until its cuts return and builds the result words. Depends on tpc_pkg,
// tpc_fifo, tpc_cut and the assertion header.
`include "triangle_plane_clipper_assert.svh"
module tpc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  tpc_pkg::qitem_t q_item,
    output logic            q_pop,
    input  logic            out_stall,
    output logic            out_valid,
    output tpc_pkg::tri_t   out_tri
);

    localparam int SIDE_W = $bits(tpc_pkg::side_t);

    logic              slot_reg;
    logic              cur_slot;
    logic              issue;
    logic              b_adv;
    tpc_pkg::edge_t    edge_sel;

    logic              res_v;
    tpc_pkg::cut_res_t res;

    tpc_pkg::side_t    side_in;
    logic [SIDE_W-1:0] side_raw;
    tpc_pkg::side_t    side_item;
    logic              side_full;
    logic              side_empty;

    logic              fin;
    logic              two;
    logic              out_free;
    tpc_pkg::vert_t    i02_reg;
    tpc_pkg::tri_t     t0, t1;
    logic              out_v_reg;
    tpc_pkg::tri_t     out_tri_reg;
    logic              pend_v_reg;
    tpc_pkg::tri_t     pend_tri_reg;

    // A passing triangle needs no cut and goes through as a single second slot.
    assign cur_slot = (q_item.mode == tpc_pkg::MODE_PASS) ? 1'b1 : slot_reg;
    assign issue    = !q_empty && b_adv;
    assign q_pop    = issue && cur_slot;

    always_comb
    begin
        edge_sel.slot = cur_slot;
        if (!cur_slot)
        begin
            edge_sel.p  = q_item.a;
            edge_sel.q  = q_item.c;
            edge_sel.sp = q_item.sa;
            edge_sel.sq = q_item.sc;
        end
        else if (q_item.mode == tpc_pkg::MODE_TWO)
        begin
            edge_sel.p  = q_item.b;
            edge_sel.q  = q_item.c;
            edge_sel.sp = q_item.sb;
            edge_sel.sq = q_item.sc;
        end
        else
        begin
            edge_sel.p  = q_item.a;
            edge_sel.q  = q_item.b;
            edge_sel.sp = q_item.sa;
            edge_sel.sq = q_item.sb;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= 1'b0;
        end
        else if (issue)
        begin
            slot_reg <= !cur_slot;
        end
    end

    tpc_cut u_cut (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (b_adv),
        .edge_v  (issue),
        .edge_in (edge_sel),
        .res_v   (res_v),
        .res     (res)
    );

    assign side_in.a    = q_item.a;
    assign side_in.b    = q_item.b;
    assign side_in.c    = q_item.c;
    assign side_in.mode = q_item.mode;

    // Holds each triangle from the issue of its last cut until that cut returns.
    tpc_fifo #(
        .WIDTH (SIDE_W),
        .DEPTH (tpc_pkg::SIDE_DEPTH)
    ) u_side (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_pop),
        .wdata (side_in),
        .pop   (fin),
        .rdata (side_raw),
        .full  (side_full),
        .empty (side_empty)
    );

    assign side_item = tpc_pkg::side_t'(side_raw);

    assign out_free = !out_v_reg || !out_stall;
    assign b_adv    = out_free && !(pend_v_reg && res_v && res.slot);
    assign fin      = res_v && res.slot && b_adv && !side_empty;

    always_comb
    begin
        t0.a    = side_item.a;
        t0.b    = side_item.b;
        t0.c    = side_item.c;
        t0.last = 1'b1;
        t1.a    = side_item.b;
        t1.b    = res.v;
        t1.c    = i02_reg;
        t1.last = 1'b1;
        two     = 1'b0;
        case (side_item.mode)
            tpc_pkg::MODE_PASS: two = 1'b0;
            tpc_pkg::MODE_ONE:
            begin
                t0.b = res.v;
                t0.c = i02_reg;
            end
            tpc_pkg::MODE_TWO:
            begin
                t0.c    = i02_reg;
                t0.last = 1'b0;
                two     = 1'b1;
            end
            default: two = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            pend_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (pend_v_reg)
            begin
                out_v_reg  <= 1'b1;
                pend_v_reg <= 1'b0;
            end
            else if (fin)
            begin
                out_v_reg  <= 1'b1;
                pend_v_reg <= two;
            end
            else
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (pend_v_reg)
            begin
                out_tri_reg <= pend_tri_reg;
            end
            else if (fin)
            begin
                out_tri_reg <= t0;
            end
        end
        if (fin)
        begin
            pend_tri_reg <= t1;
        end
        if (res_v && !res.slot && b_adv)
        begin
            i02_reg <= res.v;
        end
    end

    assign out_valid = out_v_reg;
    assign out_tri   = out_tri_reg;

    // The store is sized above the number of triangles the pipeline can hold.
    `TPC_ASSERT_IMPLIES(a_side_room, clk, rst_n, q_pop, !side_full)

endmodule

// ----- sv/triangle_plane_clipper.sv -----
// The clipper takes one triangle word per cycle while in_stall is low into a
// front end that forms the exact plane value of each vertex and sorts kept
// vertices first; triangles wholly behind the plane are dropped there. The
// back end shares one divider pipeline that cuts one edge per cycle unless
// the back end stalls: a clipped triangle sends each edge it must cut through
// it, a triangle that passes whole goes through it too. Clipping with two
// kept vertices gives two result words, the second marked last_triangle and
// sent once the first is taken. The divider of the edge cutter has 16 stages.
`include "triangle_plane_clipper_assert.svh"
module triangle_plane_clipper #(
    parameter int QUEUE_DEPTH = tpc_pkg::QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    input  logic signed [31:0] c_x,
    input  logic signed [31:0] c_y,
    input  logic signed [31:0] c_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_a_x,
    output logic signed [31:0] out_a_y,
    output logic signed [31:0] out_a_z,
    output logic signed [31:0] out_b_x,
    output logic signed [31:0] out_b_y,
    output logic signed [31:0] out_b_z,
    output logic signed [31:0] out_c_x,
    output logic signed [31:0] out_c_y,
    output logic signed [31:0] out_c_z,
    output logic               last_triangle,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int QW = $bits(tpc_pkg::qitem_t);

    tpc_pkg::vert_t [2:0] vin;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;
    tpc_pkg::qitem_t      q_wr;
    logic [QW-1:0]        q_raw;
    tpc_pkg::tri_t        tri_word;

    assign vin[0] = {a_x, a_y, a_z};
    assign vin[1] = {b_x, b_y, b_z};
    assign vin[2] = {c_x, c_y, c_z};

    tpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .vin       (vin),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (q_wr)
    );

    tpc_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wr),
        .pop   (q_pop),
        .rdata (q_raw),
        .full  (q_full),
        .empty (q_empty)
    );

    tpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (tpc_pkg::qitem_t'(q_raw)),
        .q_pop     (q_pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_tri   (tri_word)
    );

    assign out_a_x       = tri_word.a.x;
    assign out_a_y       = tri_word.a.y;
    assign out_a_z       = tri_word.a.z;
    assign out_b_x       = tri_word.b.x;
    assign out_b_y       = tri_word.b.y;
    assign out_b_z       = tri_word.b.z;
    assign out_c_x       = tri_word.c.x;
    assign out_c_y       = tri_word.c.y;
    assign out_c_z       = tri_word.c.z;
    assign last_triangle = tri_word.last;

    `TPC_ASSERT_IMPLIES(a_queue_push_room, clk, rst_n, q_push, !q_full)
    `TPC_ASSERT_IMPLIES(a_queue_pop_data, clk, rst_n, q_pop, !q_empty)
    `TPC_ASSERT_NEXT(a_pair_follows, clk, rst_n, out_valid && !out_stall && !last_triangle, out_valid && last_triangle)

endmodule
